>>> src/lrs_pkg.sv
`timescale 1ns / 1ps

package lrs_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int SLOT_WIDTH_DEF = 10;

    localparam int PAGE_SLOT_W = 10;
    localparam int VICTIM_W    = 10;
    localparam int STATUS_W    = 3;

    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    localparam logic FUNC_TOUCH = 1'b0;
    localparam logic FUNC_EVICT = 1'b1;

endpackage

>>> src/lrs_ram.sv
`timescale 1ns / 1ps

module lrs_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lru_recency_stack_top.sv
`timescale 1ns / 1ps

// LRU recency stack of page-slot indices, most recently used on top. A touch
// request (tuser 0) moves a present index to the top or pushes an absent one,
// and a miss on a full stack is rejected with status FULL; an evict request
// (tuser 1) pops and returns the least recently used index, or reports EMPTY.
// The stack lives in a single-port-read RAM of ENTRIES words, and a touch walks
// it one position per cycle, reading the next position while writing the
// previous one back shifted down. When the stack is full, a read-only search
// runs first, and the shifting walk starts again from the top only on a hit.
// A touch of an empty stack writes the index straight to the top, and an evict
// reads the bottom entry. One request is in flight at a time; a result may wait
// in the output register while the next request is taken.
module lru_recency_stack_top #(
    parameter int ENTRIES    = lrs_pkg::ENTRIES_DEF,
    parameter int SLOT_WIDTH = lrs_pkg::SLOT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] page_slot, [15:10] zero
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] victim_slot, [15:10] zero
    output logic [2:0]  m_axis_tuser    // [2:0] status
);

    import lrs_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PUSH  = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_pos, n_pos;
    logic [SLOT_WIDTH-1:0] r_key, n_key;
    logic [SLOT_WIDTH-1:0] r_carry, n_carry;
    logic                  r_shift, n_shift;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [VICTIM_W-1:0]   r_victim, n_victim;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [VICTIM_W-1:0]   r_out_victim, n_out_victim;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [SLOT_WIDTH-1:0] ram_wdata, ram_rdata;

    logic [PAGE_SLOT_W+SLOT_WIDTH-1:0] slot_ext;
    logic [SLOT_WIDTH+VICTIM_W-1:0]    victim_ext;
    logic [SLOT_WIDTH-1:0]             in_key;
    logic [CW-1:0]                     cnt_m1;
    logic                              full, hit, last;

    lrs_ram #(
        .WIDTH (SLOT_WIDTH),
        .DEPTH (ENTRIES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_ext   = {{SLOT_WIDTH{1'b0}}, s_axis_tdata[PAGE_SLOT_W-1:0]};
    assign in_key     = slot_ext[SLOT_WIDTH-1:0];
    assign victim_ext = {{VICTIM_W{1'b0}}, ram_rdata};
    assign cnt_m1     = r_count - CW'(1);
    assign full       = (r_count == CW'(ENTRIES));
    assign hit        = (ram_rdata == r_key);
    assign last       = (CW'(r_pos) == cnt_m1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - VICTIM_W){1'b0}}, r_out_victim};
    assign m_axis_tuser  = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_key        = r_key;
        n_carry      = r_carry;
        n_shift      = r_shift;
        n_status     = r_status;
        n_victim     = r_victim;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_victim = r_out_victim;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = r_carry;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_victim = '0;
                    n_key    = in_key;
                    n_carry  = in_key;
                    n_pos    = '0;
                    if (s_axis_tuser == FUNC_TOUCH) begin
                        if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = in_key;
                            n_count   = CW'(1);
                            n_status  = ST_MISS;
                            n_state   = S_FIN;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                            n_shift   = !full;
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = cnt_m1[AW-1:0];
                            n_state   = S_EVICT;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_shift) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos;
                    ram_wdata = r_carry;
                    if (hit) begin
                        n_status = ST_HIT;
                        n_state  = S_FIN;
                    end else if (last) begin
                        n_carry = ram_rdata;
                        n_state = S_PUSH;
                    end else begin
                        n_carry   = ram_rdata;
                        n_pos     = r_pos + AW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = r_pos + AW'(1);
                    end
                end else begin
                    if (hit) begin
                        n_shift   = 1'b1;
                        n_carry   = r_key;
                        n_pos     = '0;
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                    end else if (last) begin
                        n_status = ST_FULL;
                        n_state  = S_FIN;
                    end else begin
                        n_pos     = r_pos + AW'(1);
                        ram_re    = 1'b1;
                        ram_raddr = r_pos + AW'(1);
                    end
                end
            end
            S_PUSH: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[AW-1:0];
                ram_wdata = r_carry;
                n_count   = r_count + CW'(1);
                n_status  = ST_MISS;
                n_state   = S_FIN;
            end
            S_EVICT: begin
                n_victim = victim_ext[VICTIM_W-1:0];
                n_count  = cnt_m1;
                n_status = ST_EVICTED;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_victim = r_victim;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_carry      <= n_carry;
        r_shift      <= n_shift;
        r_status     <= n_status;
        r_victim     <= n_victim;
        r_out_status <= n_out_status;
        r_out_victim <= n_out_victim;
    end

endmodule
